>>> hdl/pps_pkg.sv
// Shared types and constants for the preemptive priority scheduler.
// No dependencies; used by the scheduler top level and its testbench.
package pps_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_TURN,
    ST_WAIT,
    ST_RESULT
  } state_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

  // One process table entry as stored in the entry RAM.
  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [15:0] remaining;
  } entry_t;

endpackage

>>> hdl/pps_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler: process table in one RAM, scanned per tick.
// Items are taken in ST_IDLE only. Load: the entry is written, then ST_RESULT loads the result.
// Tick item: ST_SCAN reads the entry RAM one entry per cycle, then ST_UPDATE, ST_TURN and
// ST_WAIT do the update, turnaround and waiting steps before ST_RESULT loads the result.
// A finished result waits in the output register while the next item is taken.
// Synchronous reset empties the table and clears time; RAM contents are not cleared.
module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [15:0] arrival_time,
  input  logic [15:0] burst_length,
  input  logic [7:0]  prio_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic        ran,
  output logic [3:0]  proc_index,
  output logic [31:0] time_after,
  output logic        finished,
  output logic [31:0] turnaround_time,
  output logic [31:0] waiting_time,
  output logic        all_done
);

  localparam int IW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int EW = $bits(pps_pkg::entry_t);

  pps_pkg::state_t state, state_next;

  logic [CW-1:0] entry_count;
  logic [CW-1:0] done_count;
  logic [31:0]   now_time;
  logic [CW-1:0] issue_cnt;
  logic          rd_pend;
  logic [IW-1:0] rd_idx;
  logic          have;
  logic [IW-1:0] best_idx;
  pps_pkg::entry_t best;

  logic          res_accepted;
  logic          res_ran;
  logic [IW-1:0] res_idx;
  logic          res_finished;
  logic [31:0]   res_tat;
  logic [31:0]   res_wt;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  pps_pkg::entry_t rd_e;
  pps_pkg::entry_t load_e;
  pps_pkg::entry_t upd_e;
  logic          load_ok;
  logic          issue;
  logic          elig;
  logic          better;
  logic          out_free;
  logic [15:0]   rem_dec;
  logic [15:0]   bur_fix;
  logic [32:0]   wt_diff;
  logic [IW+3:0] idx_ext;

  pps_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_PROCS)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_e     = pps_pkg::entry_t'(ram_rdata);
  assign load_ok  = entry_count < CW'(MAX_PROCS);
  assign issue    = issue_cnt < entry_count;
  assign out_free = !out_valid || !out_stall;
  assign rem_dec  = best.remaining - 16'd1;
  assign bur_fix  = (burst_length == 16'd0) ? 16'd1 : burst_length;
  assign wt_diff  = {1'b0, res_tat} - {17'd0, best.burst};
  assign idx_ext  = {4'd0, res_idx};

  // A zero remaining count marks a completed entry.
  assign elig   = (rd_e.remaining != 16'd0) && ({16'd0, rd_e.arrival} <= now_time);
  assign better = !have || (rd_e.prio < best.prio) ||
                  ((rd_e.prio == best.prio) && (rd_e.arrival < best.arrival));

  always_comb begin
    load_e.arrival   = arrival_time;
    load_e.burst     = bur_fix;
    load_e.prio      = prio_level;
    load_e.remaining = bur_fix;
    upd_e            = best;
    upd_e.remaining  = rem_dec;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pps_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = (kind == pps_pkg::KIND_LOAD) ? pps_pkg::ST_RESULT : pps_pkg::ST_SCAN;
        end
      end
      pps_pkg::ST_SCAN: begin
        if (!issue && !rd_pend) begin
          state_next = pps_pkg::ST_UPDATE;
        end
      end
      pps_pkg::ST_UPDATE: state_next = pps_pkg::ST_TURN;
      pps_pkg::ST_TURN:   state_next = pps_pkg::ST_WAIT;
      pps_pkg::ST_WAIT:   state_next = pps_pkg::ST_RESULT;
      pps_pkg::ST_RESULT: begin
        if (out_free) begin
          state_next = pps_pkg::ST_IDLE;
        end
      end
      default: state_next = pps_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = upd_e;
    ram_re    = 1'b0;
    ram_raddr = issue_cnt[IW-1:0];
    unique case (state)
      pps_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && kind == pps_pkg::KIND_LOAD && load_ok) begin
          ram_we    = 1'b1;
          ram_waddr = entry_count[IW-1:0];
          ram_wdata = load_e;
        end
      end
      pps_pkg::ST_SCAN: begin
        ram_re = issue;
      end
      pps_pkg::ST_UPDATE: begin
        ram_we = have;
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pps_pkg::ST_IDLE;
      entry_count <= '0;
      done_count  <= '0;
      now_time    <= '0;
      issue_cnt   <= '0;
      rd_pend     <= 1'b0;
      have        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        pps_pkg::ST_IDLE: begin
          if (in_valid) begin
            if (kind == pps_pkg::KIND_LOAD) begin
              if (load_ok) begin
                entry_count <= entry_count + CW'(1);
              end
            end else begin
              issue_cnt <= '0;
              rd_pend   <= 1'b0;
              have      <= 1'b0;
            end
          end
        end
        pps_pkg::ST_SCAN: begin
          if (issue) begin
            issue_cnt <= issue_cnt + CW'(1);
          end
          rd_pend <= issue;
          if (rd_pend && elig && better) begin
            have <= 1'b1;
          end
        end
        pps_pkg::ST_UPDATE: begin
          if (now_time != pps_pkg::TIME_MAX) begin
            now_time <= now_time + 32'd1;
          end
          if (have && rem_dec == 16'd0) begin
            done_count <= done_count + CW'(1);
          end
        end
        default: begin
        end
      endcase
      if (state == pps_pkg::ST_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    unique case (state)
      pps_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_ran      <= 1'b0;
          res_finished <= 1'b0;
          res_tat      <= '0;
          res_wt       <= '0;
          if (kind == pps_pkg::KIND_LOAD && load_ok) begin
            res_accepted <= 1'b1;
            res_idx      <= entry_count[IW-1:0];
          end else begin
            res_accepted <= 1'b0;
            res_idx      <= '0;
          end
        end
      end
      pps_pkg::ST_SCAN: begin
        rd_idx <= issue_cnt[IW-1:0];
        if (rd_pend && elig && better) begin
          best     <= rd_e;
          best_idx <= rd_idx;
        end
      end
      pps_pkg::ST_UPDATE: begin
        res_ran      <= have;
        res_idx      <= have ? best_idx : '0;
        res_finished <= have && (rem_dec == 16'd0);
      end
      pps_pkg::ST_TURN: begin
        res_tat <= res_finished ? (now_time - {16'd0, best.arrival}) : '0;
      end
      pps_pkg::ST_WAIT: begin
        // Clamp to zero when saturated time makes turnaround shorter than burst.
        res_wt <= (res_finished && !wt_diff[32]) ? wt_diff[31:0] : '0;
      end
      default: begin
      end
    endcase
    if (state == pps_pkg::ST_RESULT && out_free) begin
      accepted        <= res_accepted;
      ran             <= res_ran;
      proc_index      <= idx_ext[3:0];
      time_after      <= now_time;
      finished        <= res_finished;
      turnaround_time <= res_tat;
      waiting_time    <= res_wt;
      all_done        <= (done_count == entry_count);
    end
  end

endmodule

>>> hdl/pps_checker.sv
// Port-level checks for the preemptive priority scheduler.
// Depends on nothing but the top level's ports; bound to the top level below.
module pps_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        accepted,
  input logic        ran,
  input logic [3:0]  proc_index,
  input logic [31:0] time_after,
  input logic        finished,
  input logic [31:0] turnaround_time,
  input logic [31:0] waiting_time,
  input logic        all_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(time_after) && $stable(proc_index))
    else $error("stalled result changed");

  a_load_or_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && ran))
    else $error("result both loaded and ran");

  a_finish_ran: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> ran)
    else $error("finished without a run");

  a_wait_le_tat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> waiting_time <= turnaround_time)
    else $error("waiting time exceeds turnaround");

  a_done_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> !all_done || all_done)
    else $error("all_done unknown on a load result");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

>>> verif/preemptive_priority_scheduler_test.sv
// Self-checking testbench for preemptive_priority_scheduler: loads, ticks, tie breaks,
// preemption and table-full rejects, checked against an in-bench schedule predictor.
// Depends on pps_pkg and the scheduler RTL only.
module preemptive_priority_scheduler_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PROCS = 16;
  localparam int RANDOM_ITEMS = 300;

  typedef struct {
    logic        accepted;
    logic        ran;
    logic [3:0]  index;
    logic [31:0] time_after;
    logic        finished;
    logic [31:0] turnaround;
    logic [31:0] waiting;
    logic        all_done;
  } sched_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = pps_pkg::KIND_LOAD;
  logic [15:0] arrival_time = '0;
  logic [15:0] burst_length = '0;
  logic [7:0]  prio_level = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        accepted;
  logic        ran;
  logic [3:0]  proc_index;
  logic [31:0] time_after;
  logic        finished;
  logic [31:0] turnaround_time;
  logic [31:0] waiting_time;
  logic        all_done;

  // predicted scheduler state
  logic [15:0] tbl_arrival [MAX_PROCS];
  logic [15:0] tbl_burst [MAX_PROCS];
  logic [7:0]  tbl_prio [MAX_PROCS];
  logic [15:0] tbl_left [MAX_PROCS];
  logic        tbl_done [MAX_PROCS];
  int          slot_count = 0;
  int          done_count = 0;
  logic [31:0] cur_time = '0;

  sched_out_t outcome_q [$];
  int errors = 0;
  int gap_pct = 18;
  int stall_pct = 74;
  int n_items = 0, n_stored = 0, n_rejected = 0, n_ran = 0, n_idle = 0, n_finished = 0;

  preemptive_priority_scheduler #(.MAX_PROCS(MAX_PROCS)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .arrival_time(arrival_time), .burst_length(burst_length),
    .prio_level(prio_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .ran(ran), .proc_index(proc_index), .time_after(time_after),
    .finished(finished), .turnaround_time(turnaround_time), .waiting_time(waiting_time),
    .all_done(all_done)
  );

  always #2 clk = ~clk;

  initial begin
    #3ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Advance the predicted table by one item and return the result it should produce.
  function automatic sched_out_t schedule_item(logic k, logic [15:0] arr, logic [15:0] bur,
                                               logic [7:0] pri);
    sched_out_t r;
    logic       have;
    int         best;
    logic [31:0] span;
    r = '{default: '0};
    have = 1'b0;
    best = 0;
    n_items++;
    if (k == pps_pkg::KIND_LOAD) begin
      if (slot_count < MAX_PROCS) begin
        if (bur == 16'd0) bur = 16'd1;
        tbl_arrival[slot_count] = arr;
        tbl_burst[slot_count] = bur;
        tbl_prio[slot_count] = pri;
        tbl_left[slot_count] = bur;
        tbl_done[slot_count] = 1'b0;
        r.accepted = 1'b1;
        r.index = slot_count[3:0];
        slot_count++;
        n_stored++;
      end else begin
        n_rejected++;
      end
    end else begin
      for (int i = 0; i < slot_count; i++) begin
        if (tbl_done[i] || {16'd0, tbl_arrival[i]} > cur_time) continue;
        if (!have || tbl_prio[i] < tbl_prio[best] ||
            (tbl_prio[i] == tbl_prio[best] && tbl_arrival[i] < tbl_arrival[best])) begin
          best = i;
          have = 1'b1;
        end
      end
      if (cur_time != pps_pkg::TIME_MAX) cur_time++;
      if (have) begin
        n_ran++;
        r.ran = 1'b1;
        r.index = best[3:0];
        if (tbl_left[best] != 16'd0) tbl_left[best]--;
        if (tbl_left[best] == 16'd0) begin
          span = cur_time - {16'd0, tbl_arrival[best]};
          tbl_done[best] = 1'b1;
          done_count++;
          n_finished++;
          r.finished = 1'b1;
          r.turnaround = span;
          r.waiting = (span >= {16'd0, tbl_burst[best]}) ? span - {16'd0, tbl_burst[best]} : '0;
        end
      end else begin
        n_idle++;
      end
    end
    r.time_after = cur_time;
    r.all_done = (done_count == slot_count);
    return r;
  endfunction

  task automatic send_item(logic k, logic [15:0] arr, logic [15:0] bur, logic [7:0] pri);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    arrival_time <= arr;
    burst_length <= bur;
    prio_level <= pri;
    do @(posedge clk); while (in_stall);
    outcome_q.push_back(schedule_item(k, arr, bur, pri));
  endtask

  // Tick payload fields are don't-care; fill them with noise.
  task automatic send_tick();
    send_item(pps_pkg::KIND_TICK, 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    sched_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        $error("result arrived with no item pending");
        errors++;
      end else begin
        want = outcome_q.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(accepted));
        check_field("ran", 32'(want.ran), 32'(ran));
        check_field("proc_index", 32'(want.index), 32'(proc_index));
        check_field("time_after", want.time_after, time_after);
        check_field("finished", 32'(want.finished), 32'(finished));
        check_field("turnaround_time", want.turnaround, turnaround_time);
        check_field("waiting_time", want.waiting, waiting_time);
        check_field("all_done", 32'(want.all_done), 32'(all_done));
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic test_empty_table();
    send_tick();
  endtask

  task automatic test_zero_burst();
    send_item(pps_pkg::KIND_LOAD, 16'd0, 16'd0, 8'h80);
    send_tick();
  endtask

  // Lower prio wins, then earlier arrival, then lower index.
  task automatic test_tie_breaks();
    send_item(pps_pkg::KIND_LOAD, 16'd2, 16'd2, 8'd5);
    send_item(pps_pkg::KIND_LOAD, 16'd1, 16'd2, 8'd5);
    send_item(pps_pkg::KIND_LOAD, 16'd1, 16'd1, 8'd5);
    send_item(pps_pkg::KIND_LOAD, 16'd2, 16'd1, 8'd3);
    repeat (6) send_tick();
  endtask

  // Past arrival runs at once; a later high-priority arrival preempts it.
  task automatic test_late_load();
    repeat (2) send_tick();
    send_item(pps_pkg::KIND_LOAD, 16'd3, 16'd3, 8'h7F);
    send_item(pps_pkg::KIND_LOAD, cur_time[15:0] + 16'd2, 16'd1, 8'h00);
    repeat (4) send_tick();
  endtask

  task automatic test_field_extremes();
    send_item(pps_pkg::KIND_LOAD, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_tick();
  endtask

  task automatic test_random_mix(int count);
    logic [31:0] at;
    logic [15:0] arr, bur;
    logic [7:0]  pri;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 5) begin
        if ($urandom_range(9) == 0) begin
          arr = 16'($urandom_range(0, 65535));
        end else begin
          at = cur_time + $urandom_range(0, 30);
          at = (at > 8) ? at - 8 : '0;
          arr = (at > 32'hFFFF) ? 16'hFFFF : at[15:0];
        end
        bur = ($urandom_range(15) == 0) ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(0, 10));
        pri = ($urandom_range(3) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, 7));
        send_item(pps_pkg::KIND_LOAD, arr, bur, pri);
      end else begin
        send_tick();
      end
    end
  endtask

  // Fill what is left of the table, then one load must bounce.
  task automatic test_full_table();
    while (slot_count < MAX_PROCS) send_item(pps_pkg::KIND_LOAD, cur_time[15:0], 16'd2, 8'd1);
    send_item(pps_pkg::KIND_LOAD, 16'h5A5A, 16'hA5A5, 8'h3C);
    repeat (4) send_tick();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_zero_burst();
    test_tie_breaks();
    test_late_load();
    test_field_extremes();
    test_random_mix(RANDOM_ITEMS);
    wait_drained();

    gap_pct = 74;
    stall_pct = 18;
    test_random_mix(RANDOM_ITEMS);
    test_full_table();

    gap_pct = 0;
    stall_pct = 0;
    test_random_mix(RANDOM_ITEMS);

    wait_drained();
    repeat (MAX_PROCS + 10) @(posedge clk);
    if (outcome_q.size() != 0) errors++;

    $display("Covered %0d items: %0d loads stored, %0d loads rejected on a full table.",
             n_items, n_stored, n_rejected);
    $display("Ticks: %0d ran a process (%0d completions), %0d idle.",
             n_ran, n_finished, n_idle);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/pps_pkg.sv
hdl/pps_ram.sv
hdl/preemptive_priority_scheduler.sv
hdl/pps_checker.sv
verif/preemptive_priority_scheduler_test.sv
